FILE: hw/rtl/prc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    // Width of the binary angle on the ports; internally a full turn is 2^32
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int TAB_LEN    = 24;

    // CORDIC gain compensation, K * 2^31
    localparam logic [31:0] GAIN_Q31 = 32'd1304065748;

    // Shift that takes a Q31 gain product down to FRAC_BITS fraction bits
    localparam int GAIN_SHIFT = 31 - FRAC_BITS;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

    // atan(2^-i) as a 32-bit binary angle
    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Request kind carried on tuser
    typedef enum logic {
        REQ_TO_POLAR = 1'b0,
        REQ_TO_RECT  = 1'b1
    } prc_req_t;

    // Per-item control that travels down the cell chain
    typedef struct packed {
        logic polar;   // vectoring (to polar) when set, rotation otherwise
        logic zero;    // point at the origin: force magnitude and angle to zero
    } prc_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prc_pre.sv
`timescale 1ns / 1ps
`default_nettype none

module prc_pre #(
    parameter int COORD_BITS = 16,
    parameter int WIDTH      = 35
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_req,
    input  wire logic [COORD_BITS-1:0] in_real,
    input  wire logic [COORD_BITS-1:0] in_imag,
    input  wire logic [COORD_BITS-1:0] in_mag,
    input  wire logic [15:0]           in_angle,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [WIDTH-1:0]    out_x,
    output logic signed [WIDTH-1:0]    out_y,
    output logic [31:0]                out_z,
    output prc_pkg::prc_ctl_t          out_ctl
);

    localparam int PW = COORD_BITS + 34;

    // Stage 1: gain multiply
    logic signed [COORD_BITS:0] op_x, op_y;
    logic signed [32:0]         gain_s;
    logic signed [PW-1:0]       prod_x, prod_y;
    prc_pkg::prc_ctl_t          ctl1;

    logic                       v1_reg;
    logic signed [PW-1:0]       p_x_reg, p_y_reg;
    logic [15:0]                p_ang_reg;
    prc_pkg::prc_ctl_t          p_ctl_reg;
    logic                       ready1;

    // Stage 2: fold into the right half plane
    logic signed [PW-1:0]       sh_x, sh_y;
    logic signed [WIDTH-1:0]    sx, sy;
    logic signed [WIDTH-1:0]    x_next, y_next;
    logic [31:0]                z_next, z_in;

    logic                       v2_reg;
    logic signed [WIDTH-1:0]    x_reg, y_reg;
    logic [31:0]                z_reg;
    prc_pkg::prc_ctl_t          ctl_reg;

    assign gain_s = $signed({1'b0, prc_pkg::GAIN_Q31});

    always_comb begin
        ctl1.polar = (in_req == prc_pkg::REQ_TO_POLAR);
        ctl1.zero  = ctl1.polar && (in_real == '0) && (in_imag == '0);
        if (ctl1.polar) begin
            op_x = $signed({in_real[COORD_BITS-1], in_real});
            op_y = $signed({in_imag[COORD_BITS-1], in_imag});
        end else begin
            op_x = $signed({1'b0, in_mag});
            op_y = '0;
        end
        prod_x = op_x * gain_s;
        prod_y = op_y * gain_s;
    end

    assign ready1   = !v2_reg || out_ready;
    assign in_ready = !v1_reg || ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (in_ready) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p_x_reg   <= prod_x;
            p_y_reg   <= prod_y;
            p_ang_reg <= in_angle;
            p_ctl_reg <= ctl1;
        end
    end

    always_comb begin
        sh_x   = p_x_reg >>> prc_pkg::GAIN_SHIFT;
        sh_y   = p_y_reg >>> prc_pkg::GAIN_SHIFT;
        sx     = sh_x[WIDTH-1:0];
        sy     = sh_y[WIDTH-1:0];
        z_in   = {p_ang_reg, 16'h0000};
        x_next = sx;
        y_next = sy;
        z_next = '0;
        if (p_ctl_reg.polar) begin
            // turn a left-half point by pi
            if (sx[WIDTH-1]) begin
                x_next = -sx;
                y_next = -sy;
                z_next = prc_pkg::HALF_TURN;
            end
        end else begin
            z_next = z_in;
            if (z_in > prc_pkg::QUARTER_TURN && z_in < prc_pkg::THREE_QUARTER_TURN) begin
                x_next = -sx;
                z_next = z_in - prc_pkg::HALF_TURN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready1) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && v1_reg) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= p_ctl_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_ctl   = ctl_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/prc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module prc_cell #(
    parameter int SHIFT = 0,
    parameter int WIDTH = 35
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [WIDTH-1:0]  in_x,
    input  wire logic signed [WIDTH-1:0]  in_y,
    input  wire logic [31:0]              in_z,
    input  wire prc_pkg::prc_ctl_t        in_ctl,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [WIDTH-1:0]       out_x,
    output logic signed [WIDTH-1:0]       out_y,
    output logic [31:0]                   out_z,
    output prc_pkg::prc_ctl_t             out_ctl
);

    localparam logic [31:0] ATAN = prc_pkg::ATAN_TAB[SHIFT];

    logic signed [WIDTH-1:0] xs, ys;
    logic signed [WIDTH-1:0] x_next, y_next;
    logic [31:0]             z_next;
    logic                    y_pos, turn_cw;

    logic                    valid_reg;
    logic signed [WIDTH-1:0] x_reg, y_reg;
    logic [31:0]             z_reg;
    prc_pkg::prc_ctl_t       ctl_reg;

    always_comb begin
        xs    = in_x >>> SHIFT;
        ys    = in_y >>> SHIFT;
        y_pos = !in_y[WIDTH-1] && (in_y != '0);
        // vectoring steers by the sign of y, rotation by the residual angle
        turn_cw = in_ctl.polar ? y_pos : in_z[31];
        if (turn_cw) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_ctl   = ctl_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/prc_post.sv
`timescale 1ns / 1ps
`default_nettype none

module prc_post #(
    parameter int COORD_BITS = 16,
    parameter int WIDTH      = 35
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [WIDTH-1:0]  in_x,
    input  wire logic signed [WIDTH-1:0]  in_y,
    input  wire logic [31:0]              in_z,
    input  wire prc_pkg::prc_ctl_t        in_ctl,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [COORD_BITS-1:0]         out_real,
    output logic [COORD_BITS-1:0]         out_imag,
    output logic [COORD_BITS-1:0]         out_mag,
    output logic [15:0]                   out_angle
);

    localparam int RW = WIDTH - prc_pkg::FRAC_BITS;
    localparam longint SMAX_L = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint UMAX_L = (longint'(1) <<< COORD_BITS) - 1;
    localparam logic signed [RW-1:0] S_MAX = RW'(SMAX_L);
    localparam logic signed [RW-1:0] S_MIN = RW'(-SMAX_L - 1);
    localparam logic signed [RW-1:0] U_MAX = RW'(UMAX_L);
    localparam logic signed [WIDTH-1:0] HALF_LSB =
        WIDTH'(longint'(1) <<< (prc_pkg::FRAC_BITS - 1));

    logic signed [WIDTH-1:0] sum_x, sum_y;
    logic signed [RW-1:0]    rnd_x, rnd_y, sat_x, sat_y, mag_c;
    logic [31:0]             z_sum;
    logic [COORD_BITS-1:0]   real_next, imag_next, mag_next;
    logic [15:0]             angle_next;

    logic                    valid_reg;
    logic [COORD_BITS-1:0]   real_reg, imag_reg, mag_reg;
    logic [15:0]             angle_reg;

    always_comb begin
        // round half up, then floor away the fraction
        sum_x = in_x + HALF_LSB;
        sum_y = in_y + HALF_LSB;
        rnd_x = sum_x[WIDTH-1:prc_pkg::FRAC_BITS];
        rnd_y = sum_y[WIDTH-1:prc_pkg::FRAC_BITS];

        sat_x = rnd_x;
        if (rnd_x > S_MAX) sat_x = S_MAX;
        if (rnd_x < S_MIN) sat_x = S_MIN;
        sat_y = rnd_y;
        if (rnd_y > S_MAX) sat_y = S_MAX;
        if (rnd_y < S_MIN) sat_y = S_MIN;

        mag_c = rnd_x;
        if (rnd_x < 0) mag_c = '0;
        if (rnd_x > U_MAX) mag_c = U_MAX;

        z_sum = in_z + 32'h0000_8000;

        real_next  = '0;
        imag_next  = '0;
        mag_next   = '0;
        angle_next = '0;
        if (in_ctl.polar) begin
            if (!in_ctl.zero) begin
                mag_next   = mag_c[COORD_BITS-1:0];
                angle_next = z_sum[31:16];
            end
        end else begin
            real_next = sat_x[COORD_BITS-1:0];
            imag_next = sat_y[COORD_BITS-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            real_reg  <= real_next;
            imag_reg  <= imag_next;
            mag_reg   <= mag_next;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_real  = real_reg;
    assign out_imag  = imag_reg;
    assign out_mag   = mag_reg;
    assign out_angle = angle_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/polar_rect_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | tdata (low bit up)                      | tuser
// s_axis  | in  | real_in, imag_in, mag_in, angle_in      | req_type
// m_axis  | out | real_out, imag_out, mag_out, angle_out  | -
//
// Takes one request per cycle while the output is not stalled. Registered stages in order:
// gain multiply, quadrant fold, a register in each CORDIC cell, and the output register.
// Every stage has its own valid bit, so a stalled output only holds the stages
// behind it that are full; empty stages keep taking requests.
// Reset clears the valid bits only.

module polar_rect_converter #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // real_in, imag_in, mag_in, angle_in
    input  wire logic [((3*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // real_out, imag_out, mag_out, angle_out
    output logic [((3*COORD_BITS+16+7)/8)*8-1:0] m_axis_tdata
);

    localparam int DW  = ((3 * COORD_BITS + 16 + 7) / 8) * 8;
    localparam int CW  = COORD_BITS + 19;
    localparam int N   = CORDIC_STEPS;

    logic signed [CW-1:0] x_chain [N+1];
    logic signed [CW-1:0] y_chain [N+1];
    logic [31:0]          z_chain [N+1];
    prc_pkg::prc_ctl_t    c_chain [N+1];
    logic                 v_chain [N+1];
    logic                 r_chain [N+1];

    logic [COORD_BITS-1:0] real_o, imag_o, mag_o;
    logic [15:0]           angle_o;

    prc_pre #(
        .COORD_BITS (COORD_BITS),
        .WIDTH      (CW)
    ) u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_axis_tuser),
        .in_real   (s_axis_tdata[COORD_BITS-1:0]),
        .in_imag   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_mag    (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_angle  (s_axis_tdata[3*COORD_BITS+15:3*COORD_BITS]),
        .out_valid (v_chain[0]),
        .out_ready (r_chain[0]),
        .out_x     (x_chain[0]),
        .out_y     (y_chain[0]),
        .out_z     (z_chain[0]),
        .out_ctl   (c_chain[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        prc_cell #(
            .SHIFT (i),
            .WIDTH (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v_chain[i]),
            .in_ready  (r_chain[i]),
            .in_x      (x_chain[i]),
            .in_y      (y_chain[i]),
            .in_z      (z_chain[i]),
            .in_ctl    (c_chain[i]),
            .out_valid (v_chain[i+1]),
            .out_ready (r_chain[i+1]),
            .out_x     (x_chain[i+1]),
            .out_y     (y_chain[i+1]),
            .out_z     (z_chain[i+1]),
            .out_ctl   (c_chain[i+1])
        );
    end

    prc_post #(
        .COORD_BITS (COORD_BITS),
        .WIDTH      (CW)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_chain[N]),
        .in_ready  (r_chain[N]),
        .in_x      (x_chain[N]),
        .in_y      (y_chain[N]),
        .in_z      (z_chain[N]),
        .in_ctl    (c_chain[N]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_real  (real_o),
        .out_imag  (imag_o),
        .out_mag   (mag_o),
        .out_angle (angle_o)
    );

    assign m_axis_tdata = DW'({angle_o, mag_o, imag_o, real_o});

    // An empty output register must open the whole ready chain
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // A free last cell must be able to take a new request from the pre stage
    a_chain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_chain[N] |-> r_chain[0])
        else $error("ready chain blocked behind an empty cell");

    // Polar and rectangular fields are never both set in one result
    a_fields_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (mag_o != '0 || angle_o != '0))
            |-> (real_o == '0 && imag_o == '0))
        else $error("result carries both polar and rectangular fields");

    // A held result keeps its value while the sink stalls
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");

endmodule

`default_nettype wire
